// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: label");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed: label");

`else

`define ASSERT_CLK(label, clk, rst, prop)

`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// File: rtl/ptwe_pkg.sv
// ----------------------------------------------------------------------------
// ptwe_pkg
// shared types and constants of the two-level page table engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptwe_pkg;

   // entries per directory and per page table
   localparam int ENTRIES = 1024;

   // flag bit positions, same layout in directory and page entries
   localparam int FLAG_PRESENT = 0;
   localparam int FLAG_RW      = 1;
   localparam int FLAG_USER    = 2;

   typedef enum logic [1:0] {
      MODE_MAP       = 2'd0,
      MODE_UNMAP     = 2'd1,
      MODE_TRANSLATE = 2'd2,
      MODE_RANGE     = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] virt_addr;
      logic [31:0] phys_addr_in;
      logic [11:0] page_flags;
      logic [31:0] byte_count;
   } req_word_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] phys_addr;
   } rsp_word_type;

endpackage

// File: rtl/ptwe_ram.sv
// ----------------------------------------------------------------------------
// ptwe_ram
// generic single-port ram, read-first, registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptwe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                           wdata,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/two_level_page_table_engine.sv
// ----------------------------------------------------------------------------
// two_level_page_table_engine
// page directory plus pool of page tables: map, unmap, translate, range check
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over TABLE_POOL*1024 entries
// (16384 at the default pool) that zeroes the directory and the table store;
// busy is high throughout and no word is taken, while enable writes are
// accepted at any time. A word is taken when start is high and busy is low.
// Every word gives exactly one result, shown for one cycle with rsp_valid
// high; the receiver cannot stall it, so it must sample on that cycle.
// Timing is set by the two single-port memories, each with a registered read:
// a word that fails on its fields alone (disabled, misaligned, empty or
// wrapping range) returns straight from idle, a word settled by its directory
// entry (new table opened, pool exhausted, entry missing) after the directory
// read, other map, unmap and translate words after the directory read and then
// the table read, and a range check after a directory read and a table read
// for each page it walks, stopping at the first entry that fails.
// busy drops on the edge that raises rsp_valid, so the next word can be
// started while the result is on the port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module two_level_page_table_engine #(
   parameter int TABLE_POOL = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   // request word
   input  logic                   start,
   output logic                   busy,
   input  ptwe_pkg::req_word_type req_word,
   // response word
   output logic                   rsp_valid,
   output ptwe_pkg::rsp_word_type rsp_word,
   // enable register
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_enable
);

   // table store geometry
   localparam int TBL_DEPTH = TABLE_POOL * ptwe_pkg::ENTRIES;
   localparam int TADDR_W   = $clog2(TBL_DEPTH);
   localparam int IDX_W     = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
   localparam int DIR_W     = 3 + IDX_W;
   localparam int USED_W    = $clog2(TABLE_POOL + 1);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_DIR,
      S_TBL
   } state_type;

   // registers
   state_type              state_ff,    state_in;
   logic [TADDR_W-1:0]     clr_cnt_ff,  clr_cnt_in;
   logic [USED_W-1:0]      used_ff,     used_in;
   logic                   enable_ff,   enable_in;
   ptwe_pkg::req_word_type req_ff,      req_in;
   logic [19:0]            page_ff,     page_in;
   logic [19:0]            last_ff,     last_in;
   logic [IDX_W-1:0]       tidx_ff,     tidx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   ptwe_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   // memory ports
   logic               dir_we;
   logic [9:0]         dir_addr;
   logic [DIR_W-1:0]   dir_wdata;
   logic [DIR_W-1:0]   dir_q;
   logic               tbl_we;
   logic [TADDR_W-1:0] tbl_addr;
   logic [31:0]        tbl_wdata;
   logic [31:0]        tbl_q;

   // helpers
   logic [31:0] len_m1;
   logic [32:0] range_sum;
   logic        fail_fast;
   logic [11:0] flags_eff;
   logic [19:0] page_nx;
   logic        pde_ok;
   logic        pte_ok;
   logic        pde_user;
   logic        pte_user;
   logic [IDX_W-1:0] pde_idx;
   logic [IDX_W-1:0] new_idx;

   // directory: present, writable, user, pool table index
   ptwe_ram #(
      .WIDTH (DIR_W),
      .DEPTH (ptwe_pkg::ENTRIES)
   ) u_dir_ram (
      .clock (clock),
      .we    (dir_we),
      .addr  (dir_addr),
      .wdata (dir_wdata),
      .rdata (dir_q)
   );

   // table store: frame in the high 20 bits, flags in the low 12
   ptwe_ram #(
      .WIDTH (32),
      .DEPTH (TBL_DEPTH)
   ) u_tbl_ram (
      .clock (clock),
      .we    (tbl_we),
      .addr  (tbl_addr),
      .wdata (tbl_wdata),
      .rdata (tbl_q)
   );

   // range end: a carry out of the 32-bit sum means the range wraps
   assign len_m1    = req_word.byte_count - 32'd1;
   assign range_sum = {1'b0, req_word.virt_addr} + {1'b0, len_m1};

   always_comb begin
      fail_fast = !enable_ff;
      case (req_word.mode)
         ptwe_pkg::MODE_MAP: begin
            if (req_word.virt_addr[11:0] != 12'd0 || req_word.phys_addr_in[11:0] != 12'd0) begin
               fail_fast = 1'b1;
            end
         end
         ptwe_pkg::MODE_UNMAP: begin
            if (req_word.virt_addr[11:0] != 12'd0) begin
               fail_fast = 1'b1;
            end
         end
         ptwe_pkg::MODE_TRANSLATE: begin
         end
         ptwe_pkg::MODE_RANGE: begin
            if (req_word.byte_count == 32'd0 || range_sum[32]) begin
               fail_fast = 1'b1;
            end
         end
         default: begin
            fail_fast = 1'b1;
         end
      endcase
   end

   // present is forced on for every map
   assign flags_eff = req_ff.page_flags | 12'(1 << ptwe_pkg::FLAG_PRESENT);
   assign page_nx   = page_ff + 20'd1;

   assign pde_ok   = dir_q[ptwe_pkg::FLAG_PRESENT];
   assign pde_user = dir_q[ptwe_pkg::FLAG_USER];
   assign pde_idx  = dir_q[DIR_W-1:3];
   assign pte_ok   = tbl_q[ptwe_pkg::FLAG_PRESENT];
   assign pte_user = tbl_q[ptwe_pkg::FLAG_USER];
   assign new_idx  = IDX_W'(used_ff);

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      used_in      = used_ff;
      enable_in    = enable_ff;
      req_in       = req_ff;
      page_in      = page_ff;
      last_in      = last_ff;
      tidx_in      = tidx_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;

      dir_we    = 1'b0;
      dir_addr  = page_ff[19:10];
      dir_wdata = '0;
      tbl_we    = 1'b0;
      tbl_addr  = TADDR_W'({tidx_ff, page_ff[9:0]});
      tbl_wdata = '0;

      // enable register, taken in any state
      if (csr_valid) begin
         enable_in = csr_enable;
      end

      case (state_ff)
         // zero both memories, one table entry and one directory entry a cycle
         S_CLEAR: begin
            dir_we   = 1'b1;
            dir_addr = clr_cnt_ff[9:0];
            tbl_we   = 1'b1;
            tbl_addr = clr_cnt_ff;
            if (clr_cnt_ff == TADDR_W'(TBL_DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + TADDR_W'(1);
            end
         end

         // take a word and start the directory read
         S_IDLE: begin
            dir_addr = req_word.virt_addr[31:22];
            if (start) begin
               req_in  = req_word;
               page_in = req_word.virt_addr[31:12];
               last_in = range_sum[31:12];
               if (fail_fast) begin
                  rsp_valid_in = 1'b1;
                  rsp_word_in  = '0;
               end else begin
                  state_in = S_DIR;
               end
            end
         end

         // directory entry is on dir_q
         S_DIR: begin
            tbl_addr = TADDR_W'({pde_idx, page_ff[9:0]});
            tidx_in  = pde_idx;
            case (req_ff.mode)
               ptwe_pkg::MODE_MAP: begin
                  if (!pde_ok) begin
                     if (used_ff == USED_W'(TABLE_POOL)) begin
                        // pool exhausted, nothing changes
                        state_in     = S_IDLE;
                        rsp_valid_in = 1'b1;
                        rsp_word_in  = '0;
                     end else begin
                        // fresh table is still zero from the clearing pass
                        dir_we    = 1'b1;
                        dir_wdata = {new_idx, flags_eff[ptwe_pkg::FLAG_USER], 1'b1, 1'b1};
                        tbl_we    = 1'b1;
                        tbl_addr  = TADDR_W'({new_idx, page_ff[9:0]});
                        tbl_wdata = {req_ff.phys_addr_in[31:12], flags_eff};
                        used_in   = used_ff + USED_W'(1);
                        state_in  = S_IDLE;
                        rsp_valid_in = 1'b1;
                        rsp_word_in  = '{ok: 1'b1, phys_addr: 32'd0};
                     end
                  end else begin
                     // user bit sticks even if the page turns out present
                     if (flags_eff[ptwe_pkg::FLAG_USER]) begin
                        dir_we    = 1'b1;
                        dir_wdata = dir_q | DIR_W'(1 << ptwe_pkg::FLAG_USER);
                     end
                     state_in = S_TBL;
                  end
               end
               ptwe_pkg::MODE_UNMAP, ptwe_pkg::MODE_TRANSLATE: begin
                  if (pde_ok) begin
                     state_in = S_TBL;
                  end else begin
                     state_in     = S_IDLE;
                     rsp_valid_in = 1'b1;
                     rsp_word_in  = '0;
                  end
               end
               ptwe_pkg::MODE_RANGE: begin
                  if (pde_ok && pde_user) begin
                     state_in = S_TBL;
                  end else begin
                     state_in     = S_IDLE;
                     rsp_valid_in = 1'b1;
                     rsp_word_in  = '0;
                  end
               end
               default: begin
                  state_in     = S_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_word_in  = '0;
               end
            endcase
         end

         // page entry is on tbl_q
         S_TBL: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            rsp_word_in  = '0;
            case (req_ff.mode)
               ptwe_pkg::MODE_MAP: begin
                  if (!pte_ok) begin
                     tbl_we    = 1'b1;
                     tbl_wdata = {req_ff.phys_addr_in[31:12], flags_eff};
                     rsp_word_in.ok = 1'b1;
                  end
               end
               ptwe_pkg::MODE_UNMAP: begin
                  if (pte_ok) begin
                     tbl_we    = 1'b1;
                     tbl_wdata = '0;
                     rsp_word_in.ok = 1'b1;
                  end
               end
               ptwe_pkg::MODE_TRANSLATE: begin
                  if (pte_ok) begin
                     rsp_word_in = '{ok: 1'b1,
                                     phys_addr: {tbl_q[31:12], req_ff.virt_addr[11:0]}};
                  end
               end
               ptwe_pkg::MODE_RANGE: begin
                  if (pte_ok && pte_user) begin
                     if (page_ff == last_ff) begin
                        rsp_word_in.ok = 1'b1;
                     end else begin
                        // next page: read its directory entry now
                        rsp_valid_in = 1'b0;
                        page_in      = page_nx;
                        dir_addr     = page_nx[19:10];
                        state_in     = S_DIR;
                     end
                  end
               end
               default: begin
               end
            endcase
         end

         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         used_ff      <= '0;
         enable_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         used_ff      <= used_in;
         enable_ff    <= enable_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      page_ff     <= page_in;
      last_ff     <= last_in;
      tidx_ff     <= tidx_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // pool counter never passes the pool size
   `ASSERT_CLK(a_used_bound, clock, reset, used_ff <= USED_W'(TABLE_POOL))
   // a result always comes with the engine back at idle
   `ASSERT_CLK(a_rsp_idle, clock, reset, rsp_valid |-> !busy)
   // a failed result never carries an address
   `ASSERT_CLK(a_fail_zero, clock, reset, (rsp_valid && !rsp_word.ok) |-> (rsp_word.phys_addr == 32'd0))
   // the table store is never written while waiting for a word
   `ASSERT_NEVER(a_idle_nowrite, clock, reset, tbl_we && (state_ff == S_IDLE))

endmodule

// File: tb/two_level_page_table_engine_tb.sv
// ----------------------------------------------------------------------------
// two_level_page_table_engine_tb
// self-checking bench: directed and random map, unmap, translate and range
// words against an in-bench page walk predictor, with enable toggled between
// phases and the sender idling in random bursts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_level_page_table_engine_tb;

   // pool size of the instance, kept equal to the block default
   localparam int POOL_TABLES = 16;
   localparam logic [31:0] PAGE_BYTES = 32'h0000_1000;
   // upper bound on cycles to wait for the last words to come back
   localparam int DRAIN_LIMIT = 200000;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   ptwe_pkg::req_word_type req_word;
   logic                   rsp_valid;
   ptwe_pkg::rsp_word_type rsp_word;
   logic                   csr_valid;
   logic                   csr_ready;
   logic                   csr_enable;

   two_level_page_table_engine #(
      .TABLE_POOL (POOL_TABLES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_word   (rsp_word),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_enable (csr_enable)
   );

   // ------------------------------------------------------------------
   // predictor state: shadow directory, shadow table pool, enable bit
   // ------------------------------------------------------------------
   logic [31:0] dir_shadow [ptwe_pkg::ENTRIES];
   logic [31:0] pte_shadow [POOL_TABLES * ptwe_pkg::ENTRIES];
   int          tables_opened;
   logic        paging_on;

   // responses still owed by the block, oldest first
   ptwe_pkg::rsp_word_type owed_rsp [$];

   // directories that most random traffic lands in; 0..3 are adjacent so
   // range walks can cross a directory boundary, 1023 sits at the top
   int region_dir [16] = '{0, 1, 2, 3, 5, 100, 255, 256,
                           511, 512, 767, 768, 1000, 1021, 1022, 1023};

   int words_by_mode [4];
   int ok_words;
   int mismatches;
   int burst_left;

   // ------------------------------------------------------------------
   // clock
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // page walk predictor
   // ------------------------------------------------------------------

   // first shadow entry of the table a directory entry points at
   function automatic int table_base(input logic [31:0] pde);
      return int'((pde >> 3) % POOL_TABLES) * ptwe_pkg::ENTRIES;
   endfunction

   function automatic logic apply_map(input logic [31:0] va, input logic [31:0] pa,
                                      input logic [11:0] flags);
      int          di;
      int          ti;
      int          base;
      logic [11:0] f;
      logic [31:0] pde;
      di = int'(va[31:22]);
      ti = int'(va[21:12]);
      if (va[11:0] != 12'h000 || pa[11:0] != 12'h000) return 1'b0;
      f = flags;
      f[ptwe_pkg::FLAG_PRESENT] = 1'b1;
      if (!dir_shadow[di][ptwe_pkg::FLAG_PRESENT]) begin
         // fresh table out of the pool, or fail with nothing touched
         if (tables_opened >= POOL_TABLES) return 1'b0;
         for (int i = 0; i < ptwe_pkg::ENTRIES; i++)
            pte_shadow[tables_opened * ptwe_pkg::ENTRIES + i] = '0;
         pde = 32'(tables_opened) << 3;
         pde[ptwe_pkg::FLAG_PRESENT] = 1'b1;
         pde[ptwe_pkg::FLAG_RW] = 1'b1;
         pde[ptwe_pkg::FLAG_USER] = f[ptwe_pkg::FLAG_USER];
         dir_shadow[di] = pde;
         tables_opened++;
      end else if (f[ptwe_pkg::FLAG_USER]) begin
         // sticks even when the page turns out to be taken
         dir_shadow[di][ptwe_pkg::FLAG_USER] = 1'b1;
      end
      base = table_base(dir_shadow[di]);
      if (pte_shadow[base + ti][ptwe_pkg::FLAG_PRESENT]) return 1'b0;
      pte_shadow[base + ti] = {pa[31:12], f};
      return 1'b1;
   endfunction

   function automatic logic apply_unmap(input logic [31:0] va);
      int di;
      int ti;
      int base;
      di = int'(va[31:22]);
      ti = int'(va[21:12]);
      if (va[11:0] != 12'h000) return 1'b0;
      if (!dir_shadow[di][ptwe_pkg::FLAG_PRESENT]) return 1'b0;
      base = table_base(dir_shadow[di]);
      if (!pte_shadow[base + ti][ptwe_pkg::FLAG_PRESENT]) return 1'b0;
      pte_shadow[base + ti] = '0;
      return 1'b1;
   endfunction

   function automatic logic look_up(input logic [31:0] va, output logic [31:0] pa);
      logic [31:0] pde;
      logic [31:0] pte;
      pa = '0;
      pde = dir_shadow[va[31:22]];
      if (!pde[ptwe_pkg::FLAG_PRESENT]) return 1'b0;
      pte = pte_shadow[table_base(pde) + int'(va[21:12])];
      if (!pte[ptwe_pkg::FLAG_PRESENT]) return 1'b0;
      pa = {pte[31:12], va[11:0]};
      return 1'b1;
   endfunction

   function automatic logic user_range_ok(input logic [31:0] va, input logic [31:0] len);
      logic [32:0] end_addr;
      logic [31:0] pg;
      logic [31:0] last;
      logic [31:0] pde;
      logic [31:0] pte;
      logic        allowed;
      logic        walking;
      if (len == 32'd0) return 1'b0;
      end_addr = {1'b0, va} + {1'b0, len} - 33'd1;
      if (end_addr[32]) return 1'b0;
      last = {end_addr[31:12], 12'h000};
      pg = {va[31:12], 12'h000};
      allowed = 1'b1;
      walking = 1'b1;
      while (walking) begin
         pde = dir_shadow[pg[31:22]];
         pte = pte_shadow[table_base(pde) + int'(pg[21:12])];
         if (!(pde[ptwe_pkg::FLAG_PRESENT] && pde[ptwe_pkg::FLAG_USER]) ||
             !(pte[ptwe_pkg::FLAG_PRESENT] && pte[ptwe_pkg::FLAG_USER])) begin
            allowed = 1'b0;
            walking = 1'b0;
         end else if (pg >= last) begin
            walking = 1'b0;
         end else begin
            pg = pg + PAGE_BYTES;
         end
      end
      return allowed;
   endfunction

   // expected response for one accepted word; updates the shadow state
   function automatic ptwe_pkg::rsp_word_type predict_rsp(input ptwe_pkg::req_word_type w);
      ptwe_pkg::rsp_word_type r;
      logic [31:0]            pa;
      logic                   hit;
      pa = '0;
      hit = 1'b0;
      if (paging_on) begin
         case (w.mode)
            ptwe_pkg::MODE_MAP:
               hit = apply_map(w.virt_addr, w.phys_addr_in, w.page_flags);
            ptwe_pkg::MODE_UNMAP:     hit = apply_unmap(w.virt_addr);
            ptwe_pkg::MODE_TRANSLATE: hit = look_up(w.virt_addr, pa);
            default:                  hit = user_range_ok(w.virt_addr, w.byte_count);
         endcase
      end
      r.ok = hit;
      r.phys_addr = hit ? pa : 32'd0;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // word builders
   // ------------------------------------------------------------------
   function automatic ptwe_pkg::req_word_type make_word(input ptwe_pkg::mode_type m,
                                                        input logic [31:0] va,
                                                        input logic [31:0] pa,
                                                        input logic [11:0] flags,
                                                        input logic [31:0] len);
      ptwe_pkg::req_word_type w;
      w.mode = m;
      w.virt_addr = va;
      w.phys_addr_in = pa;
      w.page_flags = flags;
      w.byte_count = len;
      return w;
   endfunction

   // mostly well-formed traffic inside the region directories, some noise
   function automatic ptwe_pkg::req_word_type random_word();
      ptwe_pkg::req_word_type w;
      int unsigned            pick;
      logic [9:0]             ti;
      pick = $urandom_range(0, 99);
      if (pick < 30)      w.mode = ptwe_pkg::MODE_MAP;
      else if (pick < 45) w.mode = ptwe_pkg::MODE_UNMAP;
      else if (pick < 72) w.mode = ptwe_pkg::MODE_TRANSLATE;
      else                w.mode = ptwe_pkg::MODE_RANGE;
      if ($urandom_range(0, 99) < 88) begin
         // low table slots keep pages dense enough for hits and long walks
         ti = ($urandom_range(0, 3) != 0) ? 10'($urandom_range(0, 15))
                                          : 10'($urandom_range(0, 1023));
         w.virt_addr = {10'(region_dir[$urandom_range(0, 15)]), ti, 12'h000};
         if (w.mode == ptwe_pkg::MODE_TRANSLATE || w.mode == ptwe_pkg::MODE_RANGE ||
             $urandom_range(0, 19) == 0)
            w.virt_addr[11:0] = 12'($urandom);
      end else begin
         w.virt_addr = $urandom;
      end
      w.phys_addr_in = $urandom;
      if ($urandom_range(0, 9) != 0) w.phys_addr_in[11:0] = 12'h000;
      w.page_flags = 12'($urandom);
      if ($urandom_range(0, 3) != 0) w.page_flags[ptwe_pkg::FLAG_USER] = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 4)       w.byte_count = 32'd0;
      else if (pick < 85) w.byte_count = 32'($urandom_range(1, 32'h3000));
      else                w.byte_count = $urandom;
      return w;
   endfunction

   // ------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------

   // present one word and hold it until the block takes it
   task automatic send_word(input ptwe_pkg::req_word_type w);
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      owed_rsp.push_back(predict_rsp(w));
      words_by_mode[int'(w.mode)]++;
   endtask

   // bursts of back-to-back words with random gaps in between
   task automatic pace_sender();
      int unsigned gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 12);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(0, 10);
      end
   endtask

   // hold off the sender until every owed response is back
   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (owed_rsp.size() != 0);
   endtask

   task automatic write_enable(input logic value);
      csr_valid <= 1'b1;
      csr_enable <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      paging_on = value;
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // with paging off every mode must fail and leave the tables alone
   task automatic test_disabled_block();
      send_word(make_word(ptwe_pkg::MODE_MAP, 32'h0040_0000, 32'h0000_1000, 12'h007, 32'd0));
      send_word(make_word(ptwe_pkg::MODE_UNMAP, 32'h0040_0000, 32'd0, 12'h000, 32'd0));
      send_word(make_word(ptwe_pkg::MODE_TRANSLATE, 32'h0040_0123, 32'd0, 12'h000, 32'd0));
      send_word(make_word(ptwe_pkg::MODE_RANGE, 32'h0040_0000, 32'd0, 12'h000, 32'd1));
   endtask

   task automatic test_map_unmap();
      // present flag forced on, directory opened without user
      send_word(make_word(ptwe_pkg::MODE_MAP, 32'h0000_0000, 32'hFFFF_F000, 12'h000, 32'd0));
      send_word(make_word(ptwe_pkg::MODE_TRANSLATE, 32'h0000_0FFF, 32'd0, 12'h000, 32'd0));
      // page taken: fails, but the user flag still reaches the directory
      send_word(make_word(ptwe_pkg::MODE_MAP, 32'h0000_0000, 32'h0000_2000, 12'hFFF, 32'd0));
      // misaligned virtual, then misaligned physical
      send_word(make_word(ptwe_pkg::MODE_MAP, 32'h0000_0800, 32'h0000_3000, 12'h001, 32'd0));
      send_word(make_word(ptwe_pkg::MODE_MAP, 32'h0000_1000, 32'h0000_0001, 12'h001, 32'd0));
      send_word(make_word(ptwe_pkg::MODE_UNMAP, 32'h0000_0010, 32'd0, 12'h000, 32'd0));
      send_word(make_word(ptwe_pkg::MODE_UNMAP, 32'h0000_0000, 32'd0, 12'h000, 32'd0));
      // second unmap finds nothing, translate misses
      send_word(make_word(ptwe_pkg::MODE_UNMAP, 32'h0000_0000, 32'd0, 12'h000, 32'd0));
      send_word(make_word(ptwe_pkg::MODE_TRANSLATE, 32'h0000_0000, 32'd0, 12'h000, 32'd0));
      send_word(make_word(ptwe_pkg::MODE_MAP, 32'h0000_1000, 32'h0000_0000, 12'hFFE, 32'd0));
      send_word(make_word(ptwe_pkg::MODE_RANGE, 32'h0000_1000, 32'd0, 12'h000,
                          32'h0000_1000));
   endtask

   // open every region directory to fill the pool, then one more must fail on the exhausted pool
   task automatic test_pool_exhaustion();
      logic [31:0] pa;
      for (int k = 0; k < 16; k++) begin
         pa = {20'($urandom), 12'h000};
         send_word(make_word(ptwe_pkg::MODE_MAP, {10'(region_dir[k]), 10'h3FF, 12'h000}, pa,
                             12'h006, 32'd0));
         pace_sender();
      end
      send_word(make_word(ptwe_pkg::MODE_MAP, 32'h3840_0000, 32'h0000_5000, 12'h007, 32'd0));
   endtask

   task automatic test_range_edges();
      send_word(make_word(ptwe_pkg::MODE_MAP, 32'hFFFF_E000, 32'h1234_5000, 12'h004, 32'd0));
      // ends exactly on the last byte of the address space
      send_word(make_word(ptwe_pkg::MODE_RANGE, 32'hFFFF_E800, 32'd0, 12'h000,
                          32'h0000_1800));
      // one byte further wraps
      send_word(make_word(ptwe_pkg::MODE_RANGE, 32'hFFFF_F000, 32'd0, 12'h000,
                          32'h0000_1001));
      send_word(make_word(ptwe_pkg::MODE_RANGE, 32'hFFFF_FFFF, 32'd0, 12'h000,
                          32'hFFFF_FFFF));
      // empty range
      send_word(make_word(ptwe_pkg::MODE_RANGE, 32'h0000_2000, 32'd0, 12'h000, 32'd0));
      // whole space, stops on the unmapped first page
      send_word(make_word(ptwe_pkg::MODE_RANGE, 32'h0000_0000, 32'd0, 12'h000,
                          32'hFFFF_FFFF));
      send_word(make_word(ptwe_pkg::MODE_TRANSLATE, 32'hFFFF_FFFF, 32'd0, 12'h000, 32'd0));
   endtask

   task automatic run_random(input int count);
      for (int n = 0; n < count; n++) begin
         send_word(random_word());
         pace_sender();
      end
   endtask

   // ------------------------------------------------------------------
   // response checker: the block cannot be stalled, so every valid word
   // is taken on the cycle it shows
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_rsp
      ptwe_pkg::rsp_word_type want;
      if (!reset && rsp_valid) begin
         if (owed_rsp.size() == 0) begin
            $display("%0t unexpected response word: expected none, actual ok=%0b phys_addr=%h",
                     $time, rsp_word.ok, rsp_word.phys_addr);
            mismatches++;
         end else begin
            want = owed_rsp.pop_front();
            if (rsp_word.ok !== want.ok) begin
               $display("%0t mismatch on ok: expected %0b, actual %0b",
                        $time, want.ok, rsp_word.ok);
               mismatches++;
            end
            if (rsp_word.phys_addr !== want.phys_addr) begin
               $display("%0t mismatch on phys_addr: expected %h, actual %h",
                        $time, want.phys_addr, rsp_word.phys_addr);
               mismatches++;
            end
            if (want.ok) ok_words++;
         end
      end
   end

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------
   initial begin : main
      int waited;
      start = 1'b0;
      req_word = '0;
      csr_valid = 1'b0;
      csr_enable = 1'b0;
      reset = 1'b1;
      paging_on = 1'b0;
      tables_opened = 0;
      ok_words = 0;
      mismatches = 0;
      burst_left = 0;
      for (int i = 0; i < 4; i++) words_by_mode[i] = 0;
      for (int i = 0; i < ptwe_pkg::ENTRIES; i++) dir_shadow[i] = '0;
      for (int i = 0; i < POOL_TABLES * ptwe_pkg::ENTRIES; i++) pte_shadow[i] = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // the clearing pass after reset keeps busy high; the first word waits
      write_enable(1'b0);
      test_disabled_block();
      wait_idle();
      write_enable(1'b1);
      test_map_unmap();
      test_pool_exhaustion();
      test_range_edges();
      wait_idle();

      run_random(400);
      // full drain mid-stream, then a stretch with paging off
      wait_idle();
      write_enable(1'b0);
      run_random(60);
      wait_idle();
      write_enable(1'b1);
      run_random(440);

      start <= 1'b0;
      waited = 0;
      while (owed_rsp.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (owed_rsp.size() != 0) begin
         $display("%0t %0d response words never arrived", $time, owed_rsp.size());
         mismatches++;
      end
      // catch any stray word after the last one
      repeat (20) @(posedge clock);

      $display("covered %0d words: map %0d, unmap %0d, translate %0d, range %0d",
               words_by_mode[0] + words_by_mode[1] + words_by_mode[2] + words_by_mode[3],
               words_by_mode[0], words_by_mode[1], words_by_mode[2], words_by_mode[3]);
      $display("%0d words returned ok, %0d of %0d tables opened, enable toggled off and on",
               ok_words, tables_opened, POOL_TABLES);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin : watchdog
      #50_000_000;
      $display("%0t timeout with %0d response words owed", $time, owed_rsp.size());
      $display("FAILURE");
      $finish;
   end

endmodule
